// File: rtl/core/yaf_pkg.sv
// Package for the YUV pixel alpha fade block: widths, BT.601 coefficients,
// pipeline control type and the byte clamp function.
// No dependencies.
`default_nettype none

package yaf_pkg;

   localparam int unsigned NumStages = 4;

   // Sums of the inverse transform (YUV to RGB) and of the forward transform.
   typedef logic signed [19:0] rgb_sum_type;
   typedef logic signed [17:0] yuv_sum_type;

   // Inverse BT.601 coefficients.
   localparam rgb_sum_type CoefY  = 20'sd298;
   localparam rgb_sum_type CoefRv = 20'sd409;
   localparam rgb_sum_type CoefGu = 20'sd100;
   localparam rgb_sum_type CoefGv = 20'sd208;
   localparam rgb_sum_type CoefBu = 20'sd516;
   localparam rgb_sum_type RoundRgb = 20'sd128;

   // Forward BT.601 coefficients.
   localparam yuv_sum_type CoefYr = 18'sd66;
   localparam yuv_sum_type CoefYg = 18'sd129;
   localparam yuv_sum_type CoefYb = 18'sd25;
   localparam yuv_sum_type CoefUr = 18'sd38;
   localparam yuv_sum_type CoefUg = 18'sd74;
   localparam yuv_sum_type CoefUb = 18'sd112;
   localparam yuv_sum_type CoefVr = 18'sd112;
   localparam yuv_sum_type CoefVg = 18'sd94;
   localparam yuv_sum_type CoefVb = 18'sd18;
   localparam yuv_sum_type RoundYuv = 18'sd128;
   localparam yuv_sum_type OffsetLuma = 18'sd16;
   localparam yuv_sum_type OffsetChroma = 18'sd128;

   localparam logic [7:0] AlphaReset = 8'd255;

   typedef struct packed {
      logic [NumStages-1:0] load;
      logic [NumStages-1:0] valid;
   } stage_ctl_type;

   function automatic logic [7:0] clamp_byte(input logic signed [13:0] x);
      logic [7:0] res;
      if (x < 14'sd0) begin
         res = 8'd0;
      end else if (x > 14'sd255) begin
         res = 8'd255;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/yaf_if.sv
// Channel interfaces of the YUV pixel alpha fade block: pixel request,
// pixel response and the alpha register write channel. No dependencies.
`default_nettype none

interface yaf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_in;
   logic [7:0] cb_in;
   logic [7:0] cr_in;
   modport source (output valid, luma_in, cb_in, cr_in, input ready);
   modport sink (input valid, luma_in, cb_in, cr_in, output ready);
endinterface

interface yaf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_out;
   logic [7:0] cb_out;
   logic [7:0] cr_out;
   modport source (output valid, luma_out, cb_out, cr_out, input ready);
   modport sink (input valid, luma_out, cb_out, cr_out, output ready);
endinterface

interface yaf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] fade_alpha;
   modport source (output valid, fade_alpha, input ready);
   modport sink (input valid, fade_alpha, output ready);
endinterface

`default_nettype wire

// File: rtl/core/yaf_pipe_ctrl.sv
// Valid and load control of the four-stage fade pipeline.
// Depends on yaf_pkg.
`default_nettype none

module yaf_pipe_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic                   out_ready,
   output yaf_pkg::stage_ctl_type      ctl
);

   logic [yaf_pkg::NumStages-1:0] valid_ff;
   logic [yaf_pkg::NumStages-1:0] valid_in;
   logic [yaf_pkg::NumStages-1:0] can_load;

   // A stage takes a new beat when it is empty or its content moves on.
   always_comb begin
      can_load[yaf_pkg::NumStages-1] = !valid_ff[yaf_pkg::NumStages-1] || out_ready;
      for (int i = yaf_pkg::NumStages - 2; i >= 0; i--) begin
         can_load[i] = !valid_ff[i] || can_load[i+1];
      end
      valid_in = valid_ff;
      if (can_load[0]) begin
         valid_in[0] = in_valid;
      end
      for (int i = 1; i < yaf_pkg::NumStages; i++) begin
         if (can_load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = can_load[0];
   assign ctl      = '{load: can_load, valid: valid_ff};

endmodule

`default_nettype wire

// File: rtl/core/yaf_to_rgb.sv
// Stages one and two: YUV to RGB sums, then clamp and alpha product.
// Depends on yaf_pkg.
`default_nettype none

module yaf_to_rgb (
   input  wire logic                   clock,
   input  wire yaf_pkg::stage_ctl_type ctl,
   input  wire logic [7:0]             luma_in,
   input  wire logic [7:0]             cb_in,
   input  wire logic [7:0]             cr_in,
   input  wire logic [7:0]             alpha,
   output logic [15:0]                 r_prod,
   output logic [15:0]                 g_prod,
   output logic [15:0]                 b_prod
);

   yaf_pkg::rgb_sum_type c, d, e;
   yaf_pkg::rgb_sum_type r_sum_in, g_sum_in, b_sum_in;
   yaf_pkg::rgb_sum_type r_sum_ff, g_sum_ff, b_sum_ff;
   logic [7:0]  r_byte, g_byte, b_byte;
   logic [15:0] r_prod_ff, g_prod_ff, b_prod_ff;

   always_comb begin
      c = $signed({12'd0, luma_in}) - 20'sd16;
      d = $signed({12'd0, cb_in}) - 20'sd128;
      e = $signed({12'd0, cr_in}) - 20'sd128;
      r_sum_in = yaf_pkg::CoefY * c + yaf_pkg::CoefRv * e + yaf_pkg::RoundRgb;
      g_sum_in = yaf_pkg::CoefY * c - yaf_pkg::CoefGu * d - yaf_pkg::CoefGv * e
                 + yaf_pkg::RoundRgb;
      b_sum_in = yaf_pkg::CoefY * c + yaf_pkg::CoefBu * d + yaf_pkg::RoundRgb;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         r_sum_ff <= r_sum_in;
         g_sum_ff <= g_sum_in;
         b_sum_ff <= b_sum_in;
      end
   end

   // The arithmetic shift floors negative sums before the clamp.
   always_comb begin
      r_byte = yaf_pkg::clamp_byte(14'(r_sum_ff >>> 8));
      g_byte = yaf_pkg::clamp_byte(14'(g_sum_ff >>> 8));
      b_byte = yaf_pkg::clamp_byte(14'(b_sum_ff >>> 8));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         r_prod_ff <= r_byte * alpha;
         g_prod_ff <= g_byte * alpha;
         b_prod_ff <= b_byte * alpha;
      end
   end

   assign r_prod = r_prod_ff;
   assign g_prod = g_prod_ff;
   assign b_prod = b_prod_ff;

endmodule

`default_nettype wire

// File: rtl/core/yaf_to_yuv.sv
// Stages three and four: forward BT.601 sums of the faded RGB, then
// offset and clamp into the output register. Depends on yaf_pkg.
`default_nettype none

module yaf_to_yuv (
   input  wire logic                   clock,
   input  wire yaf_pkg::stage_ctl_type ctl,
   input  wire logic [15:0]            r_prod,
   input  wire logic [15:0]            g_prod,
   input  wire logic [15:0]            b_prod,
   output logic [7:0]                  luma_out,
   output logic [7:0]                  cb_out,
   output logic [7:0]                  cr_out
);

   yaf_pkg::yuv_sum_type r, g, b;
   yaf_pkg::yuv_sum_type y_sum_in, u_sum_in, v_sum_in;
   yaf_pkg::yuv_sum_type y_sum_ff, u_sum_ff, v_sum_ff;
   yaf_pkg::yuv_sum_type y_sh, u_sh, v_sh;
   logic [7:0] luma_ff, cb_ff, cr_ff;

   // The scaled channel is the product divided by 256.
   always_comb begin
      r = $signed({10'd0, r_prod[15:8]});
      g = $signed({10'd0, g_prod[15:8]});
      b = $signed({10'd0, b_prod[15:8]});
      y_sum_in = yaf_pkg::CoefYr * r + yaf_pkg::CoefYg * g + yaf_pkg::CoefYb * b
                 + yaf_pkg::RoundYuv;
      u_sum_in = yaf_pkg::CoefUb * b - yaf_pkg::CoefUr * r - yaf_pkg::CoefUg * g
                 + yaf_pkg::RoundYuv;
      v_sum_in = yaf_pkg::CoefVr * r - yaf_pkg::CoefVg * g - yaf_pkg::CoefVb * b
                 + yaf_pkg::RoundYuv;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         y_sum_ff <= y_sum_in;
         u_sum_ff <= u_sum_in;
         v_sum_ff <= v_sum_in;
      end
   end

   always_comb begin
      y_sh = (y_sum_ff >>> 8) + yaf_pkg::OffsetLuma;
      u_sh = (u_sum_ff >>> 8) + yaf_pkg::OffsetChroma;
      v_sh = (v_sum_ff >>> 8) + yaf_pkg::OffsetChroma;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         luma_ff <= yaf_pkg::clamp_byte(14'(y_sh));
         cb_ff   <= yaf_pkg::clamp_byte(14'(u_sh));
         cr_ff   <= yaf_pkg::clamp_byte(14'(v_sh));
      end
   end

   assign luma_out = luma_ff;
   assign cb_out   = cb_ff;
   assign cr_out   = cr_ff;

endmodule

`default_nettype wire

// File: rtl/core/yuv_pixel_alpha_fade.sv
// Top level of the YUV pixel alpha fade block.
// Depends on yaf_pkg, the channel interfaces, yaf_pipe_ctrl, yaf_to_rgb
// and yaf_to_yuv.
//
// Usage: pixels arrive as beats on req_bus (luma_in, cb_in, cr_in). Each
// pixel is converted to RGB, every channel is scaled by fade_alpha/256 and
// the result is converted back to YUV and delivered as one beat on rsp_bus.
// The csr_bus channel writes fade_alpha; it is always ready and should be
// written only while no pixel is in flight.
// Path: a beat accepted on req_bus passes through the four register stages
// in order and is shown on rsp_bus from the last one.
// Throughput: one pixel per cycle while rsp_bus is not stalled; four register
// stages, each holding one beat with its own valid bit.
// Stall: when rsp_bus.ready is low, the result holds and beats behind it
// keep moving into empty stages; req_bus.ready falls only when all four
// stages are full and the output is not taken.
// Reset: all stages are emptied and fade_alpha returns to 255.
`default_nettype none

module yuv_pixel_alpha_fade (
   input  wire logic clock,
   input  wire logic reset,
   yaf_req_if.sink   req_bus,
   yaf_rsp_if.source rsp_bus,
   yaf_csr_if.sink   csr_bus
);

   yaf_pkg::stage_ctl_type ctl;
   logic [7:0]  alpha_ff;
   logic [7:0]  alpha_in;
   logic [15:0] r_prod, g_prod, b_prod;

   assign csr_bus.ready = 1'b1;
   assign alpha_in = csr_bus.valid ? csr_bus.fade_alpha : alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= yaf_pkg::AlphaReset;
      end else begin
         alpha_ff <= alpha_in;
      end
   end

   yaf_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   yaf_to_rgb u_to_rgb (
      .clock   (clock),
      .ctl     (ctl),
      .luma_in (req_bus.luma_in),
      .cb_in   (req_bus.cb_in),
      .cr_in   (req_bus.cr_in),
      .alpha   (alpha_ff),
      .r_prod  (r_prod),
      .g_prod  (g_prod),
      .b_prod  (b_prod)
   );

   yaf_to_yuv u_to_yuv (
      .clock    (clock),
      .ctl      (ctl),
      .r_prod   (r_prod),
      .g_prod   (g_prod),
      .b_prod   (b_prod),
      .luma_out (rsp_bus.luma_out),
      .cb_out   (rsp_bus.cb_out),
      .cr_out   (rsp_bus.cr_out)
   );

   assign rsp_bus.valid = ctl.valid[yaf_pkg::NumStages-1];

endmodule

`default_nettype wire

// File: rtl/core/yaf_check.sv
// Port-level checks of the YUV pixel alpha fade block and their binding.
// Depends on yaf_pkg and yuv_pixel_alpha_fade.
`default_nettype none

module yaf_check (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic csr_ready
);

   logic [2:0] count_ff;
   logic [2:0] count_in;

   // Beats inside the block: accepted and not yet delivered.
   always_comb begin
      count_in = count_ff;
      if (req_valid && req_ready) begin
         count_in = count_in + 3'd1;
      end
      if (rsp_valid && rsp_ready) begin
         count_in = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      req_ready == ((count_ff < 3'(yaf_pkg::NumStages)) || rsp_ready))
      else $error("request ready does not match pipeline occupancy");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != 3'd0) && csr_ready)
      else $error("response beat with no request in flight");

endmodule

bind yuv_pixel_alpha_fade yaf_check u_yaf_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .csr_ready (csr_bus.ready)
);

`default_nettype wire
